// File: hdl/sixaic_pkg.sv
// ----------------------------------------------------------------------------
// Six-axis input conditioner package
// Shared constants, codes and pipeline stage types for the conditioner.
// ----------------------------------------------------------------------------
package sixaic_pkg;

    // Geometry of the state.
    localparam int AXIS_COUNT   = 6;
    localparam int AXIS_W       = 3;
    localparam int BUTTON_COUNT = 32;
    localparam int BUTTON_W     = 5;

    // Field widths.
    localparam int FIELD_W = 16;
    localparam int MOVE_W  = 25;
    localparam int TURN_W  = 18;
    localparam int GAIN_W  = 8;
    localparam int DB_W    = 7;

    // Fixed point: 12 fraction bits, 1.0 = 4096.
    localparam int FRAC_BITS = 12;

    // Relative motion mapping.
    localparam int REL_DEADBAND = 9;
    localparam int REL_CLAMP    = 410;
    localparam int REL_OFFSET   = 10;
    localparam int REL_SPAN     = 400;
    localparam int REL_N_W      = 9;
    localparam int REL_X_W      = REL_N_W + FRAC_BITS;
    localparam int REL_Q_W      = FRAC_BITS + 1;

    // Reciprocal of the span: exact floor division for all dividends in range.
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 20;
    localparam int REL_PROD_W  = REL_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'((64'd1 << RECIP_SHIFT) / REL_SPAN + 1);

    // Absolute motion mapping.
    localparam int ABS_LIMIT       = 512;
    localparam int ABS_SAT_W       = 10;
    localparam int ABS_SCALE_SHIFT = 5;

    // Magnitude of a stored axis value and of its signed square.
    localparam int MAG_W = ABS_SAT_W + ABS_SCALE_SHIFT;
    localparam int SQ_W  = TURN_W;

    // Event kinds.
    localparam logic [FIELD_W-1:0] KIND_KEY = 16'd1;
    localparam logic [FIELD_W-1:0] KIND_REL = 16'd2;
    localparam logic [FIELD_W-1:0] KIND_ABS = 16'd3;

    // Configuration register indexes.
    localparam logic CFG_ABS_DEADBAND   = 1'b0;
    localparam logic CFG_TRANSLATE_GAIN = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [DB_W-1:0]   ABS_DEADBAND_RESET   = 7'd5;
    localparam logic [GAIN_W-1:0] TRANSLATE_GAIN_RESET = 8'd20;

    // What an event does once decoded.
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_KEY  = 2'd1,
        ACT_REL  = 2'd2,
        ACT_ABS  = 2'd3
    } act_t;

    // Result of the mapping stage.
    typedef struct packed {
        act_t                act;
        logic [AXIS_W-1:0]   axis;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        logic [BUTTON_W-1:0] key_bit;
        logic                press;
    } map_t;

    // Result of the shaping stage.
    typedef struct packed {
        act_t                   act;
        logic [AXIS_W-1:0]      axis;
        logic [BUTTON_W-1:0]    key_bit;
        logic                   press;
        logic signed [SQ_W-1:0] sq;
    } shape_t;

endpackage

// File: hdl/six_axis_input_conditioner.sv
// Each beat passes the input, mapping, shaping and result registers in turn.
// Throughput: one beat per cycle; each stage register moves on when the next can take it.
// The slowest path is the reciprocal multiply of the relative mapping stage.
// Reset clears the pipeline, the six stored axes and the button mask, and sets
// abs_deadband to 5 and translate_gain to 20. There is no clearing pass.
// ----------------------------------------------------------------------------
// Six-axis input conditioner
// Maps key and motion events onto shaped six-axis outputs and a button mask.
// ----------------------------------------------------------------------------
module six_axis_input_conditioner (
    input  logic               aclk,
    input  logic               aresetn,
    // Input events.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_event_kind,
    input  logic [15:0]        s_event_code,
    input  logic signed [15:0] s_event_value,
    // Results.
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [24:0] m_move_x,
    output logic signed [24:0] m_move_y,
    output logic signed [24:0] m_move_z,
    output logic signed [17:0] m_turn_heading,
    output logic signed [17:0] m_turn_pitch,
    output logic signed [17:0] m_turn_roll,
    output logic [31:0]        m_button_mask,
    // Configuration writes.
    input  logic               cfg_wen,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wdata
);
    import sixaic_pkg::*;

    logic [FIELD_W-1:0]        kind_reg;
    logic [FIELD_W-1:0]        code_reg;
    logic signed [FIELD_W-1:0] value_reg;
    logic                      v0_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      ld0;
    logic                      ld1;
    logic                      ld2;
    logic                      ld3;
    logic [DB_W-1:0]           abs_deadband_reg;
    logic [GAIN_W-1:0]         translate_gain_reg;
    map_t                      map_q;
    shape_t                    shape_q;

    // A stage takes a new beat when it is empty or its beat moves on.
    assign ld3     = !v3_reg || m_ready;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign ld0     = !v0_reg || ld1;
    assign s_ready = ld0;
    assign m_valid = v3_reg;

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ld0) begin
                v0_reg <= s_valid;
            end
            if (ld1) begin
                v1_reg <= v0_reg;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
            if (ld3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (ld0) begin
            kind_reg  <= s_event_kind;
            code_reg  <= s_event_code;
            value_reg <= s_event_value;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_deadband_reg   <= ABS_DEADBAND_RESET;
            translate_gain_reg <= TRANSLATE_GAIN_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_ABS_DEADBAND: begin
                    abs_deadband_reg <= cfg_wdata[DB_W-1:0];
                end
                CFG_TRANSLATE_GAIN: begin
                    translate_gain_reg <= cfg_wdata;
                end
                default: begin
                    abs_deadband_reg <= abs_deadband_reg;
                end
            endcase
        end
    end

    // Event decode and value mapping.
    sixaic_map u_map (
        .aclk         (aclk),
        .load         (ld1),
        .event_kind   (kind_reg),
        .event_code   (code_reg),
        .event_value  (value_reg),
        .abs_deadband (abs_deadband_reg),
        .map_reg      (map_q)
    );

    // Signed square of the mapped value.
    sixaic_shape u_shape (
        .aclk      (aclk),
        .load      (ld2),
        .map_in    (map_q),
        .shape_reg (shape_q)
    );

    // State update and result register.
    sixaic_state u_state (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .update         (ld3 && v2_reg),
        .translate_gain (translate_gain_reg),
        .shape_in       (shape_q),
        .move_x         (m_move_x),
        .move_y         (m_move_y),
        .move_z         (m_move_z),
        .turn_heading   (m_turn_heading),
        .turn_pitch     (m_turn_pitch),
        .turn_roll      (m_turn_roll),
        .button_mask    (m_button_mask)
    );

`ifndef ASSERT_OFF
    // An empty input stage always takes a beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v0_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // A stalled mapping stage keeps its beat.
    a_map_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !ld2) |=> v1_reg)
        else $error("beat lost in mapping stage");

    // A result only appears when the shaping stage held a beat.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v2_reg))
        else $error("result beat without a source beat");
`endif

endmodule

// File: hdl/sixaic_map.sv
// ----------------------------------------------------------------------------
// Six-axis input conditioner: event mapping stage
// Decodes the event and maps a motion value onto a fixed-point magnitude.
// ----------------------------------------------------------------------------
module sixaic_map (
    input  logic                             aclk,
    input  logic                             load,
    input  logic [sixaic_pkg::FIELD_W-1:0]   event_kind,
    input  logic [sixaic_pkg::FIELD_W-1:0]   event_code,
    input  logic signed [sixaic_pkg::FIELD_W-1:0] event_value,
    input  logic [sixaic_pkg::DB_W-1:0]      abs_deadband,
    output sixaic_pkg::map_t                 map_reg
);
    import sixaic_pkg::*;

    logic [FIELD_W:0]      val_mag;
    logic                  val_neg;
    logic                  axis_ok;
    logic [AXIS_W-1:0]     rel_axis;
    logic                  swap_neg;
    logic                  rel_zero;
    logic [FIELD_W:0]      rel_clamped;
    logic [REL_N_W-1:0]    rel_n;
    logic [REL_X_W-1:0]    rel_x;
    logic [REL_PROD_W-1:0] rel_prod;
    logic [REL_Q_W-1:0]    rel_q;
    logic                  abs_zero;
    logic [ABS_SAT_W-1:0]  abs_sat;
    logic [MAG_W-1:0]      abs_mag;
    map_t                  map_next;

    // Magnitude and sign of the incoming value.
    assign val_neg = event_value[FIELD_W-1];
    assign val_mag = val_neg ? ((FIELD_W+1)'(0) - {event_value[FIELD_W-1], event_value})
                             : {1'b0, event_value};

    assign axis_ok = event_code < FIELD_W'(AXIS_COUNT);

    // Axes 1 and 2 of each triple swap places; the one moved down is negated.
    always_comb begin
        rel_axis = event_code[AXIS_W-1:0];
        swap_neg = 1'b0;
        case (event_code[AXIS_W-1:0])
            3'd1: begin
                rel_axis = 3'd2;
            end
            3'd2: begin
                rel_axis = 3'd1;
                swap_neg = 1'b1;
            end
            3'd4: begin
                rel_axis = 3'd5;
            end
            3'd5: begin
                rel_axis = 3'd4;
                swap_neg = 1'b1;
            end
            default: begin
                rel_axis = event_code[AXIS_W-1:0];
            end
        endcase
    end

    // Relative path: deadband, clamp, offset and a rounded division by the span.
    assign rel_zero    = val_mag <= (FIELD_W+1)'(REL_DEADBAND);
    assign rel_clamped = (val_mag > (FIELD_W+1)'(REL_CLAMP)) ? (FIELD_W+1)'(REL_CLAMP)
                                                              : val_mag;
    assign rel_n       = REL_N_W'(rel_clamped - (FIELD_W+1)'(REL_OFFSET));
    assign rel_x       = {rel_n, FRAC_BITS'(0)} + REL_X_W'(REL_SPAN / 2);
    assign rel_prod    = REL_PROD_W'(rel_x) * REL_PROD_W'(RECIP_MUL);
    assign rel_q       = rel_prod[RECIP_SHIFT+REL_Q_W-1:RECIP_SHIFT];

    // Absolute path: settable deadband, saturation and a scale of 1/128.
    assign abs_zero = val_mag < (FIELD_W+1)'(abs_deadband);
    assign abs_sat  = (val_mag > (FIELD_W+1)'(ABS_LIMIT)) ? ABS_SAT_W'(ABS_LIMIT)
                                                           : val_mag[ABS_SAT_W-1:0];
    assign abs_mag  = {abs_sat, ABS_SCALE_SHIFT'(0)};

    // Select the action and the mapped magnitude.
    always_comb begin
        map_next.act     = ACT_NONE;
        map_next.axis    = event_code[AXIS_W-1:0];
        map_next.neg     = val_neg;
        map_next.mag     = '0;
        map_next.key_bit = event_code[BUTTON_W-1:0];
        map_next.press   = event_value != '0;
        case (event_kind)
            KIND_KEY: begin
                map_next.act = ACT_KEY;
            end
            KIND_REL: begin
                map_next.act  = axis_ok ? ACT_REL : ACT_NONE;
                map_next.axis = rel_axis;
                map_next.neg  = val_neg ^ swap_neg;
                map_next.mag  = rel_zero ? MAG_W'(0) : MAG_W'(rel_q);
            end
            KIND_ABS: begin
                map_next.act = axis_ok ? ACT_ABS : ACT_NONE;
                map_next.mag = abs_zero ? MAG_W'(0) : abs_mag;
            end
            default: begin
                map_next.act = ACT_NONE;
            end
        endcase
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (load) begin
            map_reg <= map_next;
        end
    end

endmodule

// File: hdl/sixaic_shape.sv
// ----------------------------------------------------------------------------
// Six-axis input conditioner: shaping stage
// Forms the rounded signed square of the mapped axis value.
// ----------------------------------------------------------------------------
module sixaic_shape (
    input  logic               aclk,
    input  logic               load,
    input  sixaic_pkg::map_t   map_in,
    output sixaic_pkg::shape_t shape_reg
);
    import sixaic_pkg::*;

    logic [2*MAG_W-1:0]     mag_sq;
    logic [2*MAG_W-1:0]     rounded;
    logic signed [SQ_W-1:0] sq_mag;
    shape_t                 shape_next;

    // Square, round half up and drop the fraction bits.
    assign mag_sq  = (2*MAG_W)'(map_in.mag) * (2*MAG_W)'(map_in.mag);
    assign rounded = (mag_sq + (2*MAG_W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign sq_mag  = $signed(SQ_W'(rounded));

    // Reapply the sign of the value.
    always_comb begin
        shape_next.act     = map_in.act;
        shape_next.axis    = map_in.axis;
        shape_next.key_bit = map_in.key_bit;
        shape_next.press   = map_in.press;
        shape_next.sq      = map_in.neg ? -sq_mag : sq_mag;
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (load) begin
            shape_reg <= shape_next;
        end
    end

endmodule

// File: hdl/sixaic_state.sv
// ----------------------------------------------------------------------------
// Six-axis input conditioner: state and result stage
// Holds the shaped axes and the buttons, and registers each result beat.
// ----------------------------------------------------------------------------
module sixaic_state (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  update,
    input  logic [sixaic_pkg::GAIN_W-1:0]         translate_gain,
    input  sixaic_pkg::shape_t                    shape_in,
    output logic signed [sixaic_pkg::MOVE_W-1:0]  move_x,
    output logic signed [sixaic_pkg::MOVE_W-1:0]  move_y,
    output logic signed [sixaic_pkg::MOVE_W-1:0]  move_z,
    output logic signed [sixaic_pkg::TURN_W-1:0]  turn_heading,
    output logic signed [sixaic_pkg::TURN_W-1:0]  turn_pitch,
    output logic signed [sixaic_pkg::TURN_W-1:0]  turn_roll,
    output logic [sixaic_pkg::BUTTON_COUNT-1:0]   button_mask
);
    import sixaic_pkg::*;

    localparam int PROD_W = SQ_W + GAIN_W + 1;

    logic signed [SQ_W-1:0]   sq_reg  [AXIS_COUNT];
    logic signed [SQ_W-1:0]   sq_next [AXIS_COUNT];
    logic [BUTTON_COUNT-1:0]  buttons_reg;
    logic [BUTTON_COUNT-1:0]  buttons_next;
    logic                     axis_write;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic signed [PROD_W-1:0] prod_y_neg;
    logic signed [SQ_W-1:0]   roll_neg;

    assign axis_write = (shape_in.act == ACT_REL) || (shape_in.act == ACT_ABS);

    // Next value of every shaped axis: only the addressed one changes.
    always_comb begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
            sq_next[a] = (axis_write && (shape_in.axis == AXIS_W'(a))) ? shape_in.sq
                                                                      : sq_reg[a];
        end
    end

    // Next button mask: a key event sets or clears its bit.
    always_comb begin
        buttons_next = buttons_reg;
        if ((shape_in.act == ACT_KEY) &&
            ({1'b0, shape_in.key_bit} < (BUTTON_W+1)'(BUTTON_COUNT))) begin
            buttons_next[shape_in.key_bit] = shape_in.press;
        end
    end

    // Translation outputs carry the gain; y and roll are sign inverted.
    assign gain_s     = $signed({1'b0, translate_gain});
    assign prod_x     = PROD_W'(sq_next[0]) * PROD_W'(gain_s);
    assign prod_y     = PROD_W'(sq_next[2]) * PROD_W'(gain_s);
    assign prod_z     = PROD_W'(sq_next[1]) * PROD_W'(gain_s);
    assign prod_y_neg = -prod_y;
    assign roll_neg   = -sq_next[5];

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                sq_reg[a] <= '0;
            end
            buttons_reg <= '0;
        end else if (update) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                sq_reg[a] <= sq_next[a];
            end
            buttons_reg <= buttons_next;
        end
    end

    // Result registers, loaded with the state as it stands after the event.
    always_ff @(posedge aclk) begin
        if (update) begin
            move_x       <= MOVE_W'(prod_x);
            move_y       <= MOVE_W'(prod_y_neg);
            move_z       <= MOVE_W'(prod_z);
            turn_heading <= sq_next[4];
            turn_pitch   <= sq_next[3];
            turn_roll    <= roll_neg;
            button_mask  <= buttons_next;
        end
    end

endmodule

// File: tb/sixaic_output_checker.sv
// ----------------------------------------------------------------------------
// Six-axis input conditioner output checker
// Watches the event and result channels and the configuration port. It
// keeps its own copy of the stored axes, the button mask and the register
// settings, works out the shaped outputs for every accepted event beat and
// compares each result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sixaic_output_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [15:0]        s_event_kind,
    input  logic [15:0]        s_event_code,
    input  logic signed [15:0] s_event_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [24:0] m_move_x,
    input  logic signed [24:0] m_move_y,
    input  logic signed [24:0] m_move_z,
    input  logic signed [17:0] m_turn_heading,
    input  logic signed [17:0] m_turn_pitch,
    input  logic signed [17:0] m_turn_roll,
    input  logic [31:0]        m_button_mask,
    input  logic               cfg_wen,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wdata,
    output int                 fail_count,
    output int                 pending_count,
    output int                 frames_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import sixaic_pkg::*;

    // One predicted result beat.
    typedef struct {
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
        logic signed [MOVE_W-1:0] move_z;
        logic signed [TURN_W-1:0] turn_heading;
        logic signed [TURN_W-1:0] turn_pitch;
        logic signed [TURN_W-1:0] turn_roll;
        logic [31:0]              button_mask;
    } motion_frame_t;

    // Shadow state of the block.
    logic signed [FIELD_W-1:0] axis_value [AXIS_COUNT];
    logic [31:0]               held_buttons;
    logic [DB_W-1:0]           deadband_cfg;
    logic [GAIN_W-1:0]         gain_cfg;

    motion_frame_t expected_frames [$];

    string field_name [7] = '{"move_x", "move_y", "move_z", "turn_heading",
                              "turn_pitch", "turn_roll", "button_mask"};

    initial begin
        fail_count     = 0;
        pending_count  = 0;
        frames_checked = 0;
    end

    // Signed square of a stored axis value, rounded half up at 12 fraction bits.
    function automatic longint signed_square(input logic signed [FIELD_W-1:0] a);
        longint sq;
        sq = (longint'(a) * longint'(a) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (a < 0) ? -sq : sq;
    endfunction

    // Relative displacement: deadband, clamp and linear map onto -1..1.
    function automatic logic signed [FIELD_W-1:0] relative_axis(
        input logic signed [FIELD_W-1:0] v
    );
        int mag;
        int q;
        mag = (v < 0) ? -int'(v) : int'(v);
        if (mag <= REL_DEADBAND) return '0;
        if (mag > REL_CLAMP) mag = REL_CLAMP;
        q = ((mag - REL_OFFSET) * (1 << FRAC_BITS) + REL_SPAN / 2) / REL_SPAN;
        return (v < 0) ? FIELD_W'(-q) : FIELD_W'(q);
    endfunction

    // Absolute position: settable deadband, saturation, then scaling by 1/128.
    function automatic logic signed [FIELD_W-1:0] absolute_axis(
        input logic signed [FIELD_W-1:0] v
    );
        int mag;
        int sat;
        mag = (v < 0) ? -int'(v) : int'(v);
        if (mag < int'(deadband_cfg)) return '0;
        sat = int'(v);
        if (sat > ABS_LIMIT) sat = ABS_LIMIT;
        if (sat < -ABS_LIMIT) sat = -ABS_LIMIT;
        return FIELD_W'(sat * (1 << ABS_SCALE_SHIFT));
    endfunction

    // Updates the shadow state for one event and queues the result it gives.
    task automatic apply_event(input logic [15:0] kind, input logic [15:0] code,
                               input logic signed [15:0] value);
        motion_frame_t             frame;
        logic signed [FIELD_W-1:0] f;
        int                        axis;
        longint                    gain;
        gain = longint'(gain_cfg);
        if (kind == KIND_KEY) begin
            if (value != 0) held_buttons[code[4:0]] = 1'b1;
            else held_buttons[code[4:0]] = 1'b0;
        end else if (kind == KIND_REL) begin
            if (code < AXIS_COUNT) begin
                f    = relative_axis(value);
                axis = int'(code);
                // Within each triple the second and third axes trade places.
                if (code % 3 == 1) begin
                    axis = axis + 1;
                end else if (code % 3 == 2) begin
                    axis = axis - 1;
                    f    = -f;
                end
                axis_value[axis] = f;
            end
        end else if (kind == KIND_ABS) begin
            if (code < AXIS_COUNT) axis_value[code] = absolute_axis(value);
        end
        frame.move_x       = MOVE_W'(signed_square(axis_value[0]) * gain);
        frame.move_y       = MOVE_W'(-signed_square(axis_value[2]) * gain);
        frame.move_z       = MOVE_W'(signed_square(axis_value[1]) * gain);
        frame.turn_heading = TURN_W'(signed_square(axis_value[4]));
        frame.turn_pitch   = TURN_W'(signed_square(axis_value[3]));
        frame.turn_roll    = TURN_W'(-signed_square(axis_value[5]));
        frame.button_mask  = held_buttons;
        expected_frames.push_back(frame);
    endtask

    // Compares the result beat on the port with the oldest prediction.
    task automatic check_frame();
        motion_frame_t      want;
        logic signed [63:0] want_f [7];
        logic signed [63:0] seen_f [7];
        if (expected_frames.size() == 0) begin
            $error("result beat arrived with no prediction outstanding");
            fail_count++;
            return;
        end
        want = expected_frames.pop_front();
        want_f[0] = 64'(want.move_x);
        want_f[1] = 64'(want.move_y);
        want_f[2] = 64'(want.move_z);
        want_f[3] = 64'(want.turn_heading);
        want_f[4] = 64'(want.turn_pitch);
        want_f[5] = 64'(want.turn_roll);
        want_f[6] = 64'(want.button_mask);
        seen_f[0] = 64'(m_move_x);
        seen_f[1] = 64'(m_move_y);
        seen_f[2] = 64'(m_move_z);
        seen_f[3] = 64'(m_turn_heading);
        seen_f[4] = 64'(m_turn_pitch);
        seen_f[5] = 64'(m_turn_roll);
        seen_f[6] = 64'(m_button_mask);
        for (int i = 0; i < 7; i++) begin
            if (seen_f[i] !== want_f[i]) begin
                $error("%s mismatch: expected %0d, actual %0d",
                       field_name[i], want_f[i], seen_f[i]);
                fail_count++;
            end
        end
        frames_checked++;
    endtask

    // Sampling at the rising edge sees the values from before the edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXIS_COUNT; i++) axis_value[i] = '0;
            held_buttons = '0;
            deadband_cfg = ABS_DEADBAND_RESET;
            gain_cfg     = TRANSLATE_GAIN_RESET;
            expected_frames.delete();
            pending_count <= 0;
        end else begin
            if (m_valid && m_ready) check_frame();
            if (s_valid && s_ready) apply_event(s_event_kind, s_event_code, s_event_value);
            if (cfg_wen) begin
                if (cfg_index == CFG_ABS_DEADBAND) deadband_cfg = cfg_wdata[DB_W-1:0];
                else gain_cfg = cfg_wdata[GAIN_W-1:0];
            end
            pending_count <= expected_frames.size();
        end
    end

endmodule

// File: tb/tb_six_axis_input_conditioner.sv
// ----------------------------------------------------------------------------
// Six-axis input conditioner testbench
// Drives key, relative and absolute motion events, plus ignored ones, into
// the conditioner under several register settings with random idling on both
// channels. A separate checker predicts and compares every result beat; this
// module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_six_axis_input_conditioner;
    timeunit 1ns;
    timeprecision 1ps;
    import sixaic_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_EVENTS = 90;
    localparam int PHASES       = 7;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [15:0]        s_event_kind  = '0;
    logic [15:0]        s_event_code  = '0;
    logic signed [15:0] s_event_value = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [24:0] m_move_x;
    logic signed [24:0] m_move_y;
    logic signed [24:0] m_move_z;
    logic signed [17:0] m_turn_heading;
    logic signed [17:0] m_turn_pitch;
    logic signed [17:0] m_turn_roll;
    logic [31:0]        m_button_mask;
    logic               cfg_wen       = 1'b0;
    logic               cfg_index     = CFG_ABS_DEADBAND;
    logic [7:0]         cfg_wdata     = '0;

    int fail_count;
    int pending_count;
    int frames_checked;

    int              cycle_count    = 0;
    int              gap_pct        = 0;
    int              stall_pct      = 0;
    int              events_sent    = 0;
    int              settings_count = 0;
    logic [DB_W-1:0] cur_deadband   = ABS_DEADBAND_RESET;

    six_axis_input_conditioner i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_event_kind   (s_event_kind),
        .s_event_code   (s_event_code),
        .s_event_value  (s_event_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_move_x       (m_move_x),
        .m_move_y       (m_move_y),
        .m_move_z       (m_move_z),
        .m_turn_heading (m_turn_heading),
        .m_turn_pitch   (m_turn_pitch),
        .m_turn_roll    (m_turn_roll),
        .m_button_mask  (m_button_mask),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    sixaic_output_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_event_kind   (s_event_kind),
        .s_event_code   (s_event_code),
        .s_event_value  (s_event_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_move_x       (m_move_x),
        .m_move_y       (m_move_y),
        .m_move_z       (m_move_z),
        .m_turn_heading (m_turn_heading),
        .m_turn_pitch   (m_turn_pitch),
        .m_turn_roll    (m_turn_roll),
        .m_button_mask  (m_button_mask),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .frames_checked (frames_checked)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall bursts, otherwise always ready.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && $urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(13, 1)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Presents one event beat, after an optional idle burst, and waits for it to go.
    task automatic send_event(input logic [15:0] kind, input logic [15:0] code,
                              input logic signed [15:0] value);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_event_kind  <= kind;
        s_event_code  <= code;
        s_event_value <= value;
        do @(posedge aclk); while (!s_ready);
        events_sent++;
    endtask

    // Writes both registers once the block has drained.
    task automatic write_settings(input logic [7:0] deadband, input logic [7:0] gain);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_ABS_DEADBAND;
        cfg_wdata <= deadband;
        @(posedge aclk);
        cfg_index <= CFG_TRANSLATE_GAIN;
        cfg_wdata <= gain;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        cur_deadband = deadband[DB_W-1:0];
        settings_count++;
    endtask

    function automatic logic signed [15:0] with_random_sign(input int mag);
        return ($urandom_range(1) == 1) ? 16'(-mag) : 16'(mag);
    endfunction

    // Mostly a real axis, now and then any code at all.
    function automatic logic [15:0] pick_axis_code();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(AXIS_COUNT - 1));
    endfunction

    function automatic logic signed [15:0] pick_relative_value();
        int r;
        r = $urandom_range(9);
        if (r < 4) return with_random_sign($urandom_range(450));
        if (r < 6) return with_random_sign($urandom_range(15, 5));
        if (r < 8) return with_random_sign($urandom_range(430, 390));
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] pick_absolute_value();
        int r;
        int lo;
        r  = $urandom_range(9);
        lo = (int'(cur_deadband) > 2) ? int'(cur_deadband) - 2 : 0;
        if (r < 4) return with_random_sign($urandom_range(700));
        if (r < 6) return with_random_sign($urandom_range(int'(cur_deadband) + 2, lo));
        if (r < 8) return with_random_sign($urandom_range(525, 500));
        return 16'($urandom);
    endfunction

    // One random event; tells whether it does anything to the state.
    task automatic send_random_event(output bit effective);
        int          r;
        logic [15:0] code;
        r = $urandom_range(99);
        if (r < 25) begin
            send_event(KIND_KEY, 16'($urandom),
                       ($urandom_range(1) == 1) ? 16'sd0 : 16'($urandom));
            effective = 1'b1;
        end else if (r < 55) begin
            code = pick_axis_code();
            send_event(KIND_REL, code, pick_relative_value());
            effective = (code < AXIS_COUNT);
        end else if (r < 85) begin
            code = pick_axis_code();
            send_event(KIND_ABS, code, pick_absolute_value());
            effective = (code < AXIS_COUNT);
        end else begin
            send_event(16'($urandom), 16'($urandom), 16'($urandom));
            effective = 1'b0;
        end
    endtask

    // Stimulus and verdict.
    initial begin
        bit   effective;
        int   counted;
        int   directed;
        int   choice [4] = '{0, 10, 30, 60};
        logic [7:0] deadband;
        logic [7:0] gain;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed events under the reset settings.
        gap_pct   = 20;
        stall_pct = 20;
        send_event(KIND_KEY, 16'd0, 16'sd1);
        send_event(KIND_KEY, 16'd31, -16'sd32768);
        send_event(KIND_KEY, 16'hFFFF, 16'sd1);
        // Code 32 wraps onto button 0 and releases it.
        send_event(KIND_KEY, 16'd32, 16'sd0);
        send_event(KIND_REL, 16'd0, 16'sd32767);
        send_event(KIND_REL, 16'd1, -16'sd32768);
        send_event(KIND_REL, 16'd2, 16'sd410);
        // Inside the relative deadband, then just above it.
        send_event(KIND_REL, 16'd3, 16'sd9);
        send_event(KIND_REL, 16'd4, 16'sd10);
        send_event(KIND_REL, 16'd5, -16'sd11);
        // Just below and at the absolute deadband.
        send_event(KIND_ABS, 16'd3, 16'sd4);
        send_event(KIND_ABS, 16'd4, -16'sd5);
        send_event(KIND_ABS, 16'd5, 16'sd513);
        send_event(KIND_ABS, 16'd0, -16'sd32768);
        send_event(KIND_ABS, 16'd1, 16'sd32767);
        send_event(KIND_ABS, 16'd2, -16'sd512);
        // Axis codes out of range and unknown kinds leave the state alone.
        send_event(KIND_REL, 16'd6, 16'sd300);
        send_event(KIND_ABS, 16'hFFFF, 16'sd100);
        send_event(16'd0, 16'd1, 16'sd200);
        send_event(16'd4, 16'd2, 16'sd200);
        send_event(16'hFFFF, 16'hFFFF, -16'sd1);
        send_event(KIND_REL, 16'd3, 16'sd411);
        send_event(KIND_ABS, 16'd2, 16'sd0);
        send_event(KIND_KEY, 16'd7, 16'sd32767);
        directed = events_sent;

        // Random phases; the first two use the extreme settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                deadband = 8'h00;
                gain     = 8'h00;
            end else if (phase == 1) begin
                deadband = 8'hFF;
                gain     = 8'hFF;
            end else begin
                deadband = 8'($urandom);
                gain     = 8'($urandom);
            end
            write_settings(deadband, gain);
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = choice[$urandom_range(3)];
                stall_pct = choice[$urandom_range(3)];
            end
            counted = 0;
            while (counted < PHASE_EVENTS) begin
                send_random_event(effective);
                if (effective) counted++;
            end
        end

        // Drain and let the pipeline settle.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d event beats (%0d directed), compared %0d result beats.",
                 events_sent, directed, frames_checked);
        $display("Register settings applied after reset: %0d.", settings_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
